// ----- rtl/core/bhrg_pkg.sv -----
`timescale 1ns / 1ps

package bhrg_pkg;

   localparam int PHASE_WIDTH_DEFAULT = 16;

   localparam int TICK_WIDTH     = 16;
   localparam int PULSE_WIDTH    = 10;
   localparam int DEBOUNCE_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [TICK_WIDTH-1:0]     SHORT_CLICK_RESET    = 16'd100;
   localparam logic [TICK_WIDTH-1:0]     LONG_CLICK_RESET     = 16'd1000;
   localparam logic [TICK_WIDTH-1:0]     SHORT_HOLD_END_RESET = 16'd400;
   localparam logic [TICK_WIDTH-1:0]     LONG_HOLD_END_RESET  = 16'd4900;
   localparam logic [PULSE_WIDTH-1:0]    PULSE_RESET          = 10'd100;
   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET       = 4'd10;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_SHORT_CLICK    = 3'd0,
      REG_LONG_CLICK     = 3'd1,
      REG_SHORT_HOLD_END = 3'd2,
      REG_LONG_HOLD_END  = 3'd3,
      REG_PULSE          = 3'd4,
      REG_DEBOUNCE       = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [TICK_WIDTH-1:0]     short_click_ticks;
      logic [TICK_WIDTH-1:0]     long_click_ticks;
      logic [TICK_WIDTH-1:0]     short_hold_end_ticks;
      logic [TICK_WIDTH-1:0]     long_hold_end_ticks;
      logic [PULSE_WIDTH-1:0]    pulse_ticks;
      logic [DEBOUNCE_WIDTH-1:0] debounce_ticks;
   } cfg_type;

   typedef struct packed {
      logic button_level;
      logic release_glitch;
      logic short_select;
      logic noclick_select;
   } req_item_type;

   typedef struct packed {
      logic pulse;
      logic phase_idle;
   } core_status_type;

endpackage

// ----- rtl/core/bhrg_if.sv -----
`timescale 1ns / 1ps

interface bhrg_req_if;
   logic valid;
   logic ready;
   logic button_level;
   logic release_glitch;
   logic short_select;
   logic noclick_select;

   modport source (
      output valid, button_level, release_glitch, short_select, noclick_select,
      input  ready
   );
   modport sink (
      input  valid, button_level, release_glitch, short_select, noclick_select,
      output ready
   );
endinterface

interface bhrg_rsp_if;
   logic valid;
   logic ready;
   logic reset_out;

   modport source (
      output valid, reset_out,
      input  ready
   );
   modport sink (
      input  valid, reset_out,
      output ready
   );
endinterface

// ----- rtl/core/bhrg_core.sv -----
`timescale 1ns / 1ps

module bhrg_core #(
   parameter int PHASE_WIDTH = bhrg_pkg::PHASE_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  bhrg_pkg::req_item_type    item,
   input  bhrg_pkg::cfg_type         cfg,
   output bhrg_pkg::core_status_type status
);

   localparam int CW = (PHASE_WIDTH > bhrg_pkg::TICK_WIDTH + 1) ?
                       PHASE_WIDTH : bhrg_pkg::TICK_WIDTH + 1;
   localparam logic [PHASE_WIDTH-1:0] PHASE_IDLE = '1;

   function automatic logic [PHASE_WIDTH-1:0] clamp_phase(
      input logic [bhrg_pkg::TICK_WIDTH:0] v
   );
      logic [CW-1:0] wide;
      wide = CW'(v);
      return (wide < CW'(PHASE_IDLE)) ? wide[PHASE_WIDTH-1:0]
                                      : PHASE_IDLE - PHASE_WIDTH'(1);
   endfunction

   logic [PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic signed [4:0]      level_ff, level_in;
   logic                   pressed_ff, pressed_in;
   logic                   short_ff, short_in;
   logic                   noclick_ff, noclick_in;

   logic                   raw;
   logic signed [4:0]      lim;
   logic [PHASE_WIDTH-1:0] click_end, hold_end, pulse_start, pulse_end;
   logic [PHASE_WIDTH:0]   phase_inc;
   logic                   pulse;
   logic                   cancel;

   always_comb begin
      raw = item.button_level & ~item.release_glitch;
      lim = signed'({1'b0, cfg.debounce_ticks});

      level_in   = level_ff;
      pressed_in = pressed_ff;
      if (raw) begin
         if (level_ff <= 5'sd0) begin
            level_in = 5'sd1;
         end else if (level_ff < lim) begin
            level_in = level_ff + 5'sd1;
         end else begin
            pressed_in = 1'b1;
         end
      end else begin
         if (level_ff >= 5'sd0) begin
            level_in = -5'sd1;
         end else if (level_ff > -lim) begin
            level_in = level_ff - 5'sd1;
         end else begin
            pressed_in = 1'b0;
         end
      end

      // modes are taken on the debounced press edge
      short_in   = short_ff;
      noclick_in = noclick_ff;
      if (pressed_in && !pressed_ff) begin
         short_in   = item.short_select;
         noclick_in = item.noclick_select;
      end

      click_end   = clamp_phase({1'b0, short_in ? cfg.short_click_ticks
                                                : cfg.long_click_ticks});
      hold_end    = clamp_phase({1'b0, short_in ? cfg.short_hold_end_ticks
                                                : cfg.long_hold_end_ticks});
      pulse_start = clamp_phase({1'b0, cfg.long_hold_end_ticks});
      pulse_end   = clamp_phase({1'b0, cfg.long_hold_end_ticks} +
                                (bhrg_pkg::TICK_WIDTH + 1)'(cfg.pulse_ticks));
      phase_inc   = {1'b0, phase_ff} + (PHASE_WIDTH + 1)'(1);

      phase_in = phase_ff;
      pulse    = 1'b0;
      cancel   = 1'b0;
      if (phase_ff == PHASE_IDLE) begin
         if (pressed_in) begin
            phase_in = '0;
         end
      end else if (phase_ff < click_end) begin
         if (pressed_in) begin
            phase_in = phase_inc[PHASE_WIDTH-1:0];
         end else begin
            cancel = 1'b1;
         end
      end else if (phase_ff < hold_end) begin
         if (pressed_in) begin
            if (phase_inc < {1'b0, hold_end}) begin
               phase_in = phase_inc[PHASE_WIDTH-1:0];
            end else begin
               phase_in = pulse_start;
            end
         end else if (noclick_in) begin
            cancel = 1'b1;
         end else begin
            phase_in = pulse_start;
         end
      end else if (phase_ff < pulse_start) begin
         phase_in = pulse_start;
      end else if (phase_ff < pulse_end) begin
         pulse    = 1'b1;
         phase_in = phase_inc[PHASE_WIDTH-1:0];
      end else begin
         if (!pressed_in) begin
            cancel = 1'b1;
         end
      end

      if (cancel) begin
         pressed_in = 1'b0;
         level_in   = 5'sd0;
         phase_in   = PHASE_IDLE;
      end

      status.pulse      = pulse;
      status.phase_idle = (phase_ff == PHASE_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_IDLE;
         level_ff   <= 5'sd0;
         pressed_ff <= 1'b0;
         short_ff   <= 1'b0;
         noclick_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         level_ff   <= level_in;
         pressed_ff <= pressed_in;
         short_ff   <= short_in;
         noclick_ff <= noclick_in;
      end
   end

endmodule

// ----- rtl/core/bhrg_out_buf.sv -----
`timescale 1ns / 1ps

module bhrg_out_buf (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic push_data,
   input  logic pop,
   output logic full,
   output logic valid,
   output logic data
);

   logic [1:0] count_ff, count_in;
   logic       head_ff, head_in;
   logic       tail_ff, tail_in;
   logic       do_pop;

   always_comb begin
      do_pop   = pop && (count_ff != 2'd0);
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (push && do_pop) begin
         if (count_ff == 2'd1) begin
            head_in = push_data;
         end else begin
            head_in = tail_ff;
            tail_in = push_data;
         end
      end else if (push) begin
         count_in = count_ff + 2'd1;
         if (count_ff == 2'd0) begin
            head_in = push_data;
         end else begin
            tail_in = push_data;
         end
      end else if (do_pop) begin
         count_in = count_ff - 2'd1;
         head_in  = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign data  = head_ff;

endmodule

// ----- rtl/core/button_hold_reset_generator_top.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake     payload
// req_if    in         valid/ready   button_level, release_glitch, short_select,
//                                    noclick_select
// rsp_if    out        valid/ready   reset_out
// csr_*     in         write enable  csr_index, csr_wdata
//
// one tick transaction per cycle while ready; its result is buffered the next cycle
// the tick state updates in the accept cycle, so the output buffer sets the latency
// a two-entry output buffer keeps req_if.ready high while one result waits
// req_if.ready drops only when both buffer entries are held by a stalled rsp_if
// reset is synchronous and restores the register defaults and the idle phase

module button_hold_reset_generator_top #(
   parameter int PHASE_WIDTH = bhrg_pkg::PHASE_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bhrg_req_if.sink                             req_if,
   bhrg_rsp_if.source                           rsp_if,
   input  logic                                 csr_write_en,
   input  logic [bhrg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bhrg_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   bhrg_pkg::cfg_type         cfg_ff;
   bhrg_pkg::req_item_type    item;
   bhrg_pkg::core_status_type status;
   logic                      accept;
   logic                      buf_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_click_ticks    <= bhrg_pkg::SHORT_CLICK_RESET;
         cfg_ff.long_click_ticks     <= bhrg_pkg::LONG_CLICK_RESET;
         cfg_ff.short_hold_end_ticks <= bhrg_pkg::SHORT_HOLD_END_RESET;
         cfg_ff.long_hold_end_ticks  <= bhrg_pkg::LONG_HOLD_END_RESET;
         cfg_ff.pulse_ticks          <= bhrg_pkg::PULSE_RESET;
         cfg_ff.debounce_ticks       <= bhrg_pkg::DEBOUNCE_RESET;
      end else if (csr_write_en) begin
         unique case (bhrg_pkg::csr_index_type'(csr_index))
            bhrg_pkg::REG_SHORT_CLICK: begin
               cfg_ff.short_click_ticks <= csr_wdata;
            end
            bhrg_pkg::REG_LONG_CLICK: begin
               cfg_ff.long_click_ticks <= csr_wdata;
            end
            bhrg_pkg::REG_SHORT_HOLD_END: begin
               cfg_ff.short_hold_end_ticks <= csr_wdata;
            end
            bhrg_pkg::REG_LONG_HOLD_END: begin
               cfg_ff.long_hold_end_ticks <= csr_wdata;
            end
            bhrg_pkg::REG_PULSE: begin
               cfg_ff.pulse_ticks <= csr_wdata[bhrg_pkg::PULSE_WIDTH-1:0];
            end
            bhrg_pkg::REG_DEBOUNCE: begin
               cfg_ff.debounce_ticks <= csr_wdata[bhrg_pkg::DEBOUNCE_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_if.ready = ~buf_full;
   assign accept       = req_if.valid & ~buf_full;

   assign item.button_level   = req_if.button_level;
   assign item.release_glitch = req_if.release_glitch;
   assign item.short_select   = req_if.short_select;
   assign item.noclick_select = req_if.noclick_select;

   bhrg_core #(
      .PHASE_WIDTH(PHASE_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step_en(accept),
      .item   (item),
      .cfg    (cfg_ff),
      .status (status)
   );

   bhrg_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_data(status.pulse),
      .pop      (rsp_if.ready),
      .full     (buf_full),
      .valid    (rsp_if.valid),
      .data     (rsp_if.reset_out)
   );

`ifndef ASSERT_OFF
   a_accept_gives_result: assert property (
      @(posedge clock) disable iff (reset)
      accept |=> rsp_if.valid
   ) else $error("accepted transaction left no result");

   a_idle_no_pulse: assert property (
      @(posedge clock) disable iff (reset)
      status.phase_idle |-> !status.pulse
   ) else $error("pulse driven from idle phase");

   a_stall_only_when_held: assert property (
      @(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_if.valid
   ) else $error("input stalled with no result waiting");

   a_pulse_reaches_output: assert property (
      @(posedge clock) disable iff (reset)
      (accept && status.pulse && !rsp_if.valid) |=> rsp_if.reset_out
   ) else $error("pulse lost on the way to the output");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int PHASE_WIDTH = bhrg_pkg::PHASE_WIDTH_DEFAULT;
   localparam logic [PHASE_WIDTH-1:0] PHASE_IDLE = '1;
   localparam logic [bhrg_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED_6 = 3'd6;
   localparam logic [bhrg_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED_7 = 3'd7;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 4;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [bhrg_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [bhrg_pkg::CSR_DATA_WIDTH-1:0] csr_wdata;

   bhrg_req_if req_ch ();
   bhrg_rsp_if rsp_ch ();

   button_hold_reset_generator_top #(
      .PHASE_WIDTH(PHASE_WIDTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // press tracker state and timing copy
   bhrg_pkg::cfg_type timing;
   logic [PHASE_WIDTH-1:0] phase_q;
   int debounce_q;
   logic pressed_q;
   logic short_q;
   logic noclick_q;

   logic pending_reset_out[$];
   int unsigned failures;
   int unsigned ticks_sent;
   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned rsp_hold_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [PHASE_WIDTH-1:0] clamp_phase(input longint v);
      if (v < longint'(PHASE_IDLE)) begin
         return PHASE_WIDTH'(v);
      end
      return PHASE_IDLE - PHASE_WIDTH'(1);
   endfunction

   function automatic void drop_press();
      pressed_q = 1'b0;
      debounce_q = 0;
      phase_q = PHASE_IDLE;
   endfunction

   function automatic logic step_press_tracker(input bhrg_pkg::req_item_type t);
      logic raw;
      logic was_pressed;
      logic pulse;
      int lim;
      logic [PHASE_WIDTH-1:0] click_end;
      logic [PHASE_WIDTH-1:0] hold_end;
      logic [PHASE_WIDTH-1:0] pulse_start;
      logic [PHASE_WIDTH-1:0] pulse_end;
      raw = t.button_level & ~t.release_glitch;
      was_pressed = pressed_q;
      lim = int'(timing.debounce_ticks);
      pulse = 1'b0;
      if (raw) begin
         if (debounce_q <= 0) debounce_q = 1;
         else if (debounce_q < lim) debounce_q++;
         else pressed_q = 1'b1;
      end else begin
         if (debounce_q >= 0) debounce_q = -1;
         else if (debounce_q > -lim) debounce_q--;
         else pressed_q = 1'b0;
      end
      if (pressed_q && !was_pressed) begin
         short_q = t.short_select;
         noclick_q = t.noclick_select;
      end
      click_end = clamp_phase(longint'(short_q ? timing.short_click_ticks
                                               : timing.long_click_ticks));
      hold_end = clamp_phase(longint'(short_q ? timing.short_hold_end_ticks
                                              : timing.long_hold_end_ticks));
      pulse_start = clamp_phase(longint'(timing.long_hold_end_ticks));
      pulse_end = clamp_phase(longint'(timing.long_hold_end_ticks)
                              + longint'(timing.pulse_ticks));
      if (phase_q == PHASE_IDLE) begin
         if (pressed_q) phase_q = '0;
      end else if (phase_q < click_end) begin
         if (pressed_q) phase_q++;
         else drop_press();
      end else if (phase_q < hold_end) begin
         if (pressed_q) begin
            if (longint'(phase_q) + 1 < longint'(hold_end)) phase_q++;
            else phase_q = pulse_start;
         end else if (noclick_q) begin
            drop_press();
         end else begin
            phase_q = pulse_start;
         end
      end else if (phase_q < pulse_start) begin
         phase_q = pulse_start;
      end else if (phase_q < pulse_end) begin
         pulse = 1'b1;
         phase_q++;
      end else if (!pressed_q) begin
         drop_press();
      end
      return pulse;
   endfunction

   // transaction monitor and result check
   always @(posedge clock) begin : scoreboard
      bhrg_pkg::req_item_type tick;
      logic want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_reset_out.size() == 0) begin
               $error("reset_out: unexpected transaction, expected none, actual %0b",
                      rsp_ch.reset_out);
               failures++;
            end else begin
               want = pending_reset_out.pop_front();
               if (rsp_ch.reset_out !== want) begin
                  $error("reset_out: expected %0b, actual %0b", want, rsp_ch.reset_out);
                  failures++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            tick.button_level = req_ch.button_level;
            tick.release_glitch = req_ch.release_glitch;
            tick.short_select = req_ch.short_select;
            tick.noclick_select = req_ch.noclick_select;
            pending_reset_out.push_back(step_press_tracker(tick));
         end
      end
   end

   initial begin : rsp_sink
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_tick(input bhrg_pkg::req_item_type t);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.button_level <= t.button_level;
      req_ch.release_glitch <= t.release_glitch;
      req_ch.short_select <= t.short_select;
      req_ch.noclick_select <= t.noclick_select;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_reset_out.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [bhrg_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [bhrg_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         bhrg_pkg::REG_SHORT_CLICK: timing.short_click_ticks = data;
         bhrg_pkg::REG_LONG_CLICK: timing.long_click_ticks = data;
         bhrg_pkg::REG_SHORT_HOLD_END: timing.short_hold_end_ticks = data;
         bhrg_pkg::REG_LONG_HOLD_END: timing.long_hold_end_ticks = data;
         bhrg_pkg::REG_PULSE: timing.pulse_ticks = data[bhrg_pkg::PULSE_WIDTH-1:0];
         bhrg_pkg::REG_DEBOUNCE:
            timing.debounce_ticks = data[bhrg_pkg::DEBOUNCE_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_timing(input logic [bhrg_pkg::CSR_DATA_WIDTH-1:0] short_click,
                                 input logic [bhrg_pkg::CSR_DATA_WIDTH-1:0] long_click,
                                 input logic [bhrg_pkg::CSR_DATA_WIDTH-1:0] short_hold,
                                 input logic [bhrg_pkg::CSR_DATA_WIDTH-1:0] long_hold,
                                 input logic [bhrg_pkg::CSR_DATA_WIDTH-1:0] pulse_len,
                                 input logic [bhrg_pkg::CSR_DATA_WIDTH-1:0] debounce_len);
      wait_idle();
      write_csr(bhrg_pkg::REG_SHORT_CLICK, short_click);
      write_csr(bhrg_pkg::REG_LONG_CLICK, long_click);
      write_csr(bhrg_pkg::REG_SHORT_HOLD_END, short_hold);
      write_csr(bhrg_pkg::REG_LONG_HOLD_END, long_hold);
      write_csr(bhrg_pkg::REG_PULSE, pulse_len);
      write_csr(bhrg_pkg::REG_DEBOUNCE, debounce_len);
   endtask

   task automatic press_release(input int unsigned press_len, release_len,
                                input logic short_sel, noclick_sel);
      repeat (press_len) send_tick('{1'b1, 1'b0, short_sel, noclick_sel});
      repeat (release_len) send_tick('{1'b0, 1'b0, short_sel, noclick_sel});
   endtask

   function automatic bhrg_pkg::req_item_type make_tick(input logic level);
      bhrg_pkg::req_item_type t;
      t.button_level = level;
      t.release_glitch = ($urandom_range(24) == 0);
      t.short_select = 1'($urandom_range(1));
      t.noclick_select = 1'($urandom_range(1));
      return t;
   endfunction

   // press/release sequences with random content, plus some noise
   task automatic run_press_sequences(input int unsigned n_ticks);
      int unsigned stop_at;
      int unsigned reach;
      int unsigned press_len;
      int unsigned release_len;
      stop_at = ticks_sent + n_ticks;
      reach = int'(timing.debounce_ticks) + int'(timing.short_hold_end_ticks)
              + int'(timing.long_hold_end_ticks) + int'(timing.pulse_ticks) + 6;
      while (ticks_sent < stop_at) begin
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 6)) send_tick(make_tick(1'($urandom_range(1))));
         end else begin
            press_len = $urandom_range(1, reach);
            release_len = $urandom_range(1, 2 * int'(timing.debounce_ticks) + 4);
            repeat (press_len) send_tick(make_tick(1'b1));
            repeat (release_len) send_tick(make_tick(1'b0));
         end
      end
   endtask

   task automatic test_reset_defaults();
      send_tick('{1'b1, 1'b1, 1'b0, 1'b0});
      press_release(3, 2, 1'b1, 1'b1);
   endtask

   task automatic test_register_masking();
      wait_idle();
      write_csr(REG_UNUSED_6, 16'hFFFF);
      write_csr(REG_UNUSED_7, 16'h0001);
      program_timing(16'd0, 16'hFFFF, 16'd1, 16'd2, 16'hFC02, 16'hFFF0);
      press_release(7, 3, 1'b1, 1'b0);
   endtask

   task automatic test_release_in_hold();
      program_timing(16'd1, 16'd2, 16'd6, 16'd8, 16'd1, 16'd0);
      press_release(4, 4, 1'b1, 1'b0);
      press_release(4, 4, 1'b1, 1'b1);
   endtask

   task automatic test_pulse_limits();
      program_timing(16'd0, 16'd1, 16'd1, 16'd3, 16'd0, 16'd1);
      press_release(6, 3, 1'b1, 1'b0);
      program_timing(16'd0, 16'd1, 16'd1, 16'hFFFF, 16'd5, 16'd0);
      press_release(5, 3, 1'b1, 1'b0);
      program_timing(16'd0, 16'd1, 16'd1, 16'd65530, 16'd1000, 16'd0);
      press_release(9, 3, 1'b1, 1'b0);
   endtask

   task automatic test_random_timing();
      repeat (8) begin
         program_timing(16'($urandom_range(0, 10)), 16'($urandom_range(0, 16)),
                        16'($urandom_range(0, 20)), 16'($urandom_range(0, 30)),
                        16'($urandom_range(0, 12)), 16'($urandom_range(0, 4)));
         run_press_sequences(150);
      end
   endtask

   task automatic test_back_to_back();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_press_sequences(150);
      req_idle_pct = 26;
      rsp_idle_pct = 26;
   endtask

   task automatic test_output_backpressure();
      req_idle_pct = 0;
      rsp_hold_left = 60;
      run_press_sequences(40);
      req_idle_pct = 26;
   endtask

   initial begin
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.button_level <= 1'b0;
      req_ch.release_glitch <= 1'b0;
      req_ch.short_select <= 1'b0;
      req_ch.noclick_select <= 1'b0;
      timing = '{bhrg_pkg::SHORT_CLICK_RESET, bhrg_pkg::LONG_CLICK_RESET,
                 bhrg_pkg::SHORT_HOLD_END_RESET, bhrg_pkg::LONG_HOLD_END_RESET,
                 bhrg_pkg::PULSE_RESET, bhrg_pkg::DEBOUNCE_RESET};
      phase_q = PHASE_IDLE;
      debounce_q = 0;
      pressed_q = 1'b0;
      short_q = 1'b0;
      noclick_q = 1'b0;
      failures = 0;
      ticks_sent = 0;
      req_idle_pct = 26;
      rsp_idle_pct = 26;
      rsp_hold_left = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_register_masking();
      test_release_in_hold();
      test_pulse_limits();
      test_random_timing();
      test_back_to_back();
      test_output_backpressure();
      wait_idle();
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
